// ===== rtl/core/wto_pkg.sv =====
// Shared constants and register codes for the wavetable oscillator.
package wto_pkg;

    // Fixed field widths
    localparam int PHASE_W     = 32;
    localparam int LEN_W       = 11;
    localparam int IDX_W       = 10;
    localparam int FRAC_BITS   = 16;

    // Configuration port
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 32;

    localparam logic [CFG_INDEX_W-1:0] REG_PHASE_INC = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_TABLE_LEN = 2'd1;

    localparam logic [LEN_W-1:0] TABLE_LEN_RESET = 11'd1024;

    // Command codes
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_TICK = 1'b1;

    // Parameter defaults
    localparam int DEF_TABLE_DEPTH = 1024;
    localparam int DEF_SAMPLE_BITS = 16;

endpackage

// ===== rtl/core/wto_mul.sv =====
// Shared signed multiplier with a registered product.
module wto_mul #(
    parameter int A_W = 17,
    parameter int B_W = 33
) (
    input  logic                       clk,
    input  logic                       en,
    input  logic signed [A_W-1:0]      a,
    input  logic signed [B_W-1:0]      b,
    output logic signed [A_W+B_W-1:0]  product
);

    logic signed [A_W+B_W-1:0] product_reg;
    logic signed [A_W+B_W-1:0] product_next;

    // Form the full-width product
    assign product_next = (A_W+B_W)'(a) * (A_W+B_W)'(b);

    // Hold the product until the next enabled cycle
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            product_reg <= product_next;
        end
    end

    assign product = product_reg;

endmodule

// ===== rtl/core/wavetable_oscillator_interp_unit.sv =====
// Wavetable oscillator top level: phase accumulator, wave table and interpolation sequencer.
// Load word: written to the table at the accept edge if its index is in range, no result.
// Tick word: steps MUL, RD0, RD1, INTERP, DONE to the result; one shared multiplier is used
// twice (length times phase, then difference times fraction) and the single table port is
// read twice. One load every cycle while idle; no word is taken during a tick and its sample
// waits in the output register while the next word is taken. Reset clears the sequencer,
// phase, increment and length (1024); table contents stay undefined until written.
module wavetable_oscillator_interp_unit
    import wto_pkg::*;
#(
    parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
    parameter int SAMPLE_BITS = DEF_SAMPLE_BITS
) (
    input  logic                          clk,
    input  logic                          rst_n,
    // configuration
    input  logic                          cfg_write,
    input  logic [CFG_INDEX_W-1:0]        cfg_index,
    input  logic [CFG_DATA_W-1:0]         cfg_data,
    // input channel
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic                          command,
    input  logic [IDX_W-1:0]              entry_index,
    input  logic signed [SAMPLE_BITS-1:0] entry_value,
    // output channel
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic signed [SAMPLE_BITS-1:0] sample
);

    localparam int ADDR_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
    localparam int DIFF_W = SAMPLE_BITS + 1;
    localparam int MUL_A_W = (DIFF_W > LEN_W + 1) ? DIFF_W : LEN_W + 1;
    localparam int MUL_B_W = PHASE_W + 1;
    localparam int PROD_W = MUL_A_W + MUL_B_W;

    localparam logic [2:0] ST_IDLE   = 3'd0;
    localparam logic [2:0] ST_MUL    = 3'd1;
    localparam logic [2:0] ST_RD0    = 3'd2;
    localparam logic [2:0] ST_RD1    = 3'd3;
    localparam logic [2:0] ST_INTERP = 3'd4;
    localparam logic [2:0] ST_DONE   = 3'd5;

    logic [2:0]                   state_reg, state_next;
    logic [PHASE_W-1:0]           phase_inc_reg;
    logic [LEN_W-1:0]             table_len_reg;
    logic [PHASE_W-1:0]           phase_reg;
    logic                         out_valid_reg;
    logic signed [SAMPLE_BITS-1:0] sample_reg;

    logic signed [SAMPLE_BITS-1:0] wave_table [TABLE_DEPTH];
    logic signed [SAMPLE_BITS-1:0] rd_data_reg;
    logic signed [SAMPLE_BITS-1:0] s0_reg;
    logic [ADDR_W-1:0]             i1_reg;
    logic [FRAC_BITS-1:0]          frac_reg;

    logic                          in_accept;
    logic                          tick_accept;
    logic                          load_accept;
    logic                          out_load;
    logic [LEN_W-1:0]              eff_len;
    logic [LEN_W-1:0]              i0;
    logic [LEN_W:0]                i0_plus;
    logic [ADDR_W-1:0]             rd_addr;
    logic signed [DIFF_W-1:0]      diff;
    logic                          mul_en;
    logic signed [MUL_A_W-1:0]     mul_a;
    logic signed [MUL_B_W-1:0]     mul_b;
    logic signed [PROD_W-1:0]      prod;
    logic signed [SAMPLE_BITS-1:0] sample_next;

    // Handshake decode
    assign in_stall    = (state_reg != ST_IDLE);
    assign in_accept   = in_valid && !in_stall;
    assign tick_accept = in_accept && (command == CMD_TICK);
    assign load_accept = in_accept && (command == CMD_LOAD)
                         && (32'(entry_index) < 32'(TABLE_DEPTH));
    assign out_load    = (state_reg == ST_DONE) && (!out_valid_reg || !out_stall);

    // Clamp the table length to 1..TABLE_DEPTH
    always_comb
    begin
        if (table_len_reg == '0)
        begin
            eff_len = LEN_W'(1);
        end
        else if (32'(table_len_reg) > 32'(TABLE_DEPTH))
        begin
            eff_len = LEN_W'(TABLE_DEPTH);
        end
        else
        begin
            eff_len = table_len_reg;
        end
    end

    // Split the scaled phase into entry index and fraction
    assign i0      = prod[PHASE_W +: LEN_W];
    assign i0_plus = {1'b0, i0} + (LEN_W+1)'(1);
    assign rd_addr = (state_reg == ST_RD0) ? ADDR_W'(i0) : i1_reg;

    // Shared multiplier operands: length by phase, then difference by fraction
    assign diff   = DIFF_W'(rd_data_reg) - DIFF_W'(s0_reg);
    assign mul_en = (state_reg == ST_MUL) || (state_reg == ST_INTERP);
    assign mul_a  = (state_reg == ST_MUL) ? MUL_A_W'($signed({1'b0, eff_len}))
                                          : MUL_A_W'(diff);
    assign mul_b  = (state_reg == ST_MUL) ? $signed({1'b0, phase_reg})
                                          : MUL_B_W'($signed({1'b0, frac_reg}));

    wto_mul #(
        .A_W (MUL_A_W),
        .B_W (MUL_B_W)
    ) u_mul (
        .clk     (clk),
        .en      (mul_en),
        .a       (mul_a),
        .b       (mul_b),
        .product (prod)
    );

    // Floor shift of the weighted difference, added to the first entry
    assign sample_next = s0_reg + $signed(prod[FRAC_BITS +: SAMPLE_BITS]);

    // Sequence one tick word through the shared unit
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:   if (tick_accept) state_next = ST_MUL;
            ST_MUL:    state_next = ST_RD0;
            ST_RD0:    state_next = ST_RD1;
            ST_RD1:    state_next = ST_INTERP;
            ST_INTERP: state_next = ST_DONE;
            ST_DONE:   if (out_load) state_next = ST_IDLE;
            default:   state_next = ST_IDLE;
        endcase
    end

    // Control state, configuration and phase
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            phase_inc_reg <= '0;
            table_len_reg <= TABLE_LEN_RESET;
            phase_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_write && (cfg_index == REG_PHASE_INC))
            begin
                phase_inc_reg <= cfg_data[PHASE_W-1:0];
            end
            if (cfg_write && (cfg_index == REG_TABLE_LEN))
            begin
                table_len_reg <= cfg_data[LEN_W-1:0];
            end
            // advance phase, wrapping modulo one waveform period
            if (tick_accept)
            begin
                phase_reg <= phase_reg + phase_inc_reg;
            end
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Wave table: one write or one registered read per cycle
    always_ff @(posedge clk)
    begin
        if (load_accept)
        begin
            wave_table[ADDR_W'(entry_index)] <= entry_value;
        end
        else
        begin
            rd_data_reg <= wave_table[rd_addr];
        end
    end

    // Datapath holding registers
    always_ff @(posedge clk)
    begin
        if (state_reg == ST_RD0)
        begin
            frac_reg <= prod[FRAC_BITS +: FRAC_BITS];
            i1_reg   <= (i0_plus == {1'b0, eff_len}) ? '0 : ADDR_W'(i0_plus);
        end
        if (state_reg == ST_RD1)
        begin
            s0_reg <= rd_data_reg;
        end
        if (out_load)
        begin
            sample_reg <= sample_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign sample    = sample_reg;

    // A new result appears only out of the final step
    a_result_from_done: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_DONE))
        else $error("result raised outside the final step");

    // An accepted tick starts the multiply step
    a_tick_starts: assert property (@(posedge clk) disable iff (!rst_n)
        tick_accept |=> (state_reg == ST_MUL))
        else $error("accepted tick did not start the sequence");

    // A load word leaves the phase alone
    a_load_keeps_phase: assert property (@(posedge clk) disable iff (!rst_n)
        (in_accept && (command == CMD_LOAD)) |=> $stable(phase_reg))
        else $error("load word changed the phase");

    // A held result is not overwritten while stalled
    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall && (state_reg == ST_DONE)) |=> (state_reg == ST_DONE))
        else $error("sequencer left the final step over a stalled result");

endmodule
